// ===== hdl/avmpq_pkg.sv =====
// shared types and key function for the absolute-value min priority queue
// no dependencies; imported by the top level

package avmpq_pkg;

	localparam int VALUE_W = 32;
	localparam int KEY_W   = VALUE_W + 1;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [KEY_W-1:0]          key_t;

	// ordering key: magnitude above, low bit set for positive values
	function automatic key_t key_of(input value_t v);
		logic [VALUE_W-1:0] mag;
		mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
		return {mag, ~v[VALUE_W-1]};
	endfunction

endpackage

// ===== hdl/avmpq_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies

module avmpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/abs_value_min_priority_queue.sv =====
// absolute-value min priority queue: heap sequencer around one heap ram
// depends on avmpq_pkg and avmpq_ram

// Usage:
// - input channel (value_valid / value_stall / value): a nonzero value is
//   pushed, zero requests a pop of the entry with the smallest magnitude
//   (negative first on equal magnitude).
// - result channel (result_valid / result_stall / popped_value / overflow):
//   one result per pop (0 when empty) and one per push into a full heap
//   (overflow set, popped_value 0); a successful push gives no result.
// - one request is worked at a time; value_stall is high while busy.
// - push: the accept cycle, then for each parent compared a read of the parent
//   and a compare/move, and a final write when it climbs to the root.
// - pop: a fetch of the root and the last entry, then for each level walked
//   down a read of the left child, a read of the right child and a
//   compare/move, then it finishes; the single ram read port keeps these
//   reads apart.
// - the result sits in an output register; a stalled result holds and the
//   next request is still taken, but a request that makes a result waits
//   until the register is free.
// - reset empties the queue at once (entry count cleared, no ram sweep).

module abs_value_min_priority_queue #(
	parameter int HEAP_DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                value_valid,
	output logic                value_stall,
	input  avmpq_pkg::value_t   value,
	output logic                result_valid,
	input  logic                result_stall,
	output avmpq_pkg::value_t   popped_value,
	output logic                overflow
);

	import avmpq_pkg::*;

	localparam int AW = $clog2(HEAP_DEPTH);
	localparam int CW = $clog2(HEAP_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH_RD,
		S_PUSH_CMP,
		S_PUSH_WR,
		S_POP_TOP,
		S_POP_LAST,
		S_POP_LOAD,
		S_POP_CHK,
		S_POP_C1,
		S_POP_C2,
		S_EMIT
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   child_q;
	value_t          item_q;
	value_t          best_q;
	value_t          res_val_q;
	logic            res_ovf_q;
	logic            result_valid_q;
	value_t          popped_value_q;
	logic            overflow_q;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	value_t          ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	value_t          ram_rdata;

	logic            accept;
	logic [CW-1:0]   parent;
	logic [CW:0]     left_c;
	logic [CW:0]     right_c;
	logic            has_left;
	logic            has_right;
	logic            right_wins;
	value_t          cand;
	logic [CW-1:0]   cand_idx;
	logic            cand_stays;
	logic            out_free;

	assign accept      = value_valid && (state_q == S_IDLE);
	assign value_stall = (state_q != S_IDLE);

	assign parent    = (idx_q - CW'(1)) >> 1;
	assign left_c    = {idx_q, 1'b1};
	assign right_c   = {1'b0, child_q} + (CW+1)'(1);
	assign has_left  = left_c < {1'b0, count_q};
	assign has_right = right_c < {1'b0, count_q};

	// pick the smaller child; on a tie the left one stays
	assign right_wins = (state_q == S_POP_C2) && (key_of(ram_rdata) < key_of(best_q));
	assign cand       = (state_q == S_POP_C1 || right_wins) ? ram_rdata : best_q;
	assign cand_idx   = right_wins ? right_c[CW-1:0] : child_q;
	assign cand_stays = key_of(cand) >= key_of(item_q);

	assign out_free = !result_valid_q || !result_stall;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = item_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_PUSH_RD: begin
				ram_re    = 1'b1;
				ram_raddr = parent[AW-1:0];
			end
			S_PUSH_CMP: begin
				ram_we = 1'b1;
				if (key_of(ram_rdata) > key_of(item_q)) begin
					ram_wdata = ram_rdata;
				end
			end
			S_PUSH_WR: begin
				ram_we = 1'b1;
			end
			S_POP_TOP: begin
				ram_re = 1'b1;
			end
			S_POP_LAST: begin
				ram_re    = 1'b1;
				ram_raddr = count_q[AW-1:0];
			end
			S_POP_CHK: begin
				if (has_left) begin
					ram_re    = 1'b1;
					ram_raddr = left_c[AW-1:0];
				end else begin
					ram_we = 1'b1;
				end
			end
			S_POP_C1: begin
				if (has_right) begin
					ram_re    = 1'b1;
					ram_raddr = right_c[AW-1:0];
				end else begin
					ram_we = 1'b1;
					if (!cand_stays) begin
						ram_wdata = cand;
					end
				end
			end
			S_POP_C2: begin
				ram_we = 1'b1;
				if (!cand_stays) begin
					ram_wdata = cand;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// in S_EMIT the result register is handled by that state alone
			if (result_valid_q && !result_stall && state_q != S_EMIT) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						item_q <= value;
						idx_q  <= count_q;
						if (value == '0) begin
							if (count_q == '0) begin
								res_val_q <= '0;
								res_ovf_q <= 1'b0;
								state_q   <= S_EMIT;
							end else begin
								count_q <= count_q - CW'(1);
								state_q <= S_POP_TOP;
							end
						end else if (count_q == CW'(HEAP_DEPTH)) begin
							res_val_q <= '0;
							res_ovf_q <= 1'b1;
							state_q   <= S_EMIT;
						end else begin
							count_q <= count_q + CW'(1);
							state_q <= (count_q == '0) ? S_PUSH_WR : S_PUSH_RD;
						end
					end
				end
				S_PUSH_RD: begin
					state_q <= S_PUSH_CMP;
				end
				S_PUSH_CMP: begin
					if (key_of(ram_rdata) > key_of(item_q)) begin
						idx_q   <= parent;
						state_q <= (parent == '0) ? S_PUSH_WR : S_PUSH_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_PUSH_WR: begin
					state_q <= S_IDLE;
				end
				S_POP_TOP: begin
					state_q <= S_POP_LAST;
				end
				S_POP_LAST: begin
					res_val_q <= ram_rdata;
					res_ovf_q <= 1'b0;
					state_q   <= S_POP_LOAD;
				end
				S_POP_LOAD: begin
					// the old last entry sifts down from the root
					item_q  <= ram_rdata;
					idx_q   <= '0;
					state_q <= (count_q == '0) ? S_EMIT : S_POP_CHK;
				end
				S_POP_CHK: begin
					if (has_left) begin
						child_q <= left_c[CW-1:0];
						state_q <= S_POP_C1;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_POP_C1: begin
					if (has_right) begin
						best_q  <= ram_rdata;
						state_q <= S_POP_C2;
					end else if (cand_stays) begin
						state_q <= S_EMIT;
					end else begin
						idx_q   <= cand_idx;
						state_q <= S_POP_CHK;
					end
				end
				S_POP_C2: begin
					if (cand_stays) begin
						state_q <= S_EMIT;
					end else begin
						idx_q   <= cand_idx;
						state_q <= S_POP_CHK;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						popped_value_q <= res_val_q;
						overflow_q     <= res_ovf_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign popped_value = popped_value_q;
	assign overflow     = overflow_q;

	avmpq_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (HEAP_DEPTH)
	) u_heap_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(HEAP_DEPTH))
		else $error("entry count above heap depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		(count_q == $past(count_q) + CW'(1) || count_q == $past(count_q) - CW'(1)))
		else $error("entry count moved by more than one");

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re && ram_waddr == ram_raddr))
		else $error("heap ram read and write to the same entry");

	a_overflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && overflow) |-> (popped_value == '0))
		else $error("overflow result carries a value");

endmodule
